@@ src/dlefr_pkg.sv @@
package dlefr_pkg;

    // Frame geometry
    localparam int DATA_MAX = 32;
    localparam int LEN_W    = $clog2(DATA_MAX + 1);
    localparam int ADDR_W   = (DATA_MAX > 1) ? $clog2(DATA_MAX) : 1;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int TICK_W   = 16;
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 3;

    // Line control characters
    localparam logic [BYTE_W-1:0] CH_DLE = 8'h10;
    localparam logic [BYTE_W-1:0] CH_STX = 8'h02;
    localparam logic [BYTE_W-1:0] CH_ETX = 8'h03;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;

    // Register index, taken from paddr[2]
    localparam logic REG_TIMEOUT = 1'b0;

    // Input action codes
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Receive modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_CMD  = 2'd1;
    localparam logic [1:0] MODE_DATA = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_CMD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

endpackage

@@ src/dlefr_if.sv @@
interface dlefr_in_if;
    import dlefr_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface dlefr_out_if;
    import dlefr_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] value;
    logic              last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

@@ src/dle_stx_etx_frame_receiver.sv @@
// DLE/STX/ETX deframer for a raw serial byte stream.
//
// in_ch carries one request per received byte (action = byte) or per timer
// tick (action = tick). out_ch carries the results: at DLE ETX the frame
// comes out as a run (command byte, then each data byte, last marked), and
// each framing fault comes out as one error event with last set.
// The APB port holds timeout_ticks at address 0 (paddr[2] low).
//
// Flow: a byte or tick request is taken whenever the block is idle and the
// output register is free or being drained in that cycle; its result, if any,
// appears in the output register on the next cycle. A frame's data bytes are
// read out of the payload memory through its single registered read port:
// each data byte passes through S_ISSUE (read issued), then S_WAIT (read data
// loaded into the output register). No request is taken during the readout.
//
// Reset clears mode, escape flag, command byte, length, tick count and the
// output register and loads timeout_ticks with 1000. The payload memory is
// not cleared: only entries below the length are ever read.
// When out_ch stalls, the result holds in the output register and in_ch
// drops ready until it can be taken (or, during readout, the walk pauses).
module dle_stx_etx_frame_receiver (
    input  logic                             clk,
    input  logic                             rst_n,
    dlefr_in_if.sink                         in_ch,
    dlefr_out_if.source                      out_ch,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dlefr_pkg::PADDR_W-1:0]    paddr,
    input  logic [dlefr_pkg::PDATA_W-1:0]    pwdata,
    output logic [dlefr_pkg::PDATA_W-1:0]    prdata,
    output logic                             pready
);
    import dlefr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT
    } state_t;

    // Control state
    state_t              st_reg,        st_next;
    logic [1:0]          mode_reg,      mode_next;
    logic                esc_reg,       esc_next;
    logic [BYTE_W-1:0]   cmd_reg,       cmd_next;
    logic [LEN_W-1:0]    len_reg,       len_next;
    logic [TICK_W-1:0]   cnt_reg,       cnt_next;
    logic [TICK_W-1:0]   timeout_reg;
    logic [ADDR_W-1:0]   rd_idx_reg,    rd_idx_next;

    // Output register
    logic                ovalid_reg,    ovalid_next;
    logic [KIND_W-1:0]   okind_reg,     okind_next;
    logic [BYTE_W-1:0]   ovalue_reg,    ovalue_next;
    logic                olast_reg,     olast_next;

    // Payload memory
    logic [BYTE_W-1:0]   mem [DATA_MAX];
    logic [BYTE_W-1:0]   mem_q;
    logic                mem_we;
    logic                mem_re;

    logic                out_free;
    logic                in_acc;
    logic                in_frame;
    logic                content;
    logic                emit_err;
    logic                emit_frame;
    logic [TICK_W:0]     cnt_inc;
    logic                cfg_wr;

    assign out_free = !ovalid_reg || out_ch.ready;
    assign in_ch.ready = (st_reg == S_IDLE) && out_free;
    assign in_acc = in_ch.valid && in_ch.ready;
    assign in_frame = mode_reg inside {MODE_CMD, MODE_DATA};
    assign cnt_inc = {1'b0, cnt_reg} + {{TICK_W{1'b0}}, 1'b1};

    assign out_ch.valid = ovalid_reg;
    assign out_ch.kind  = okind_reg;
    assign out_ch.value = ovalue_reg;
    assign out_ch.last  = olast_reg;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TIMEOUT);
    assign prdata = (paddr[2] == REG_TIMEOUT) ? {{(PDATA_W-TICK_W){1'b0}}, timeout_reg}
                                               : '0;

    always_comb
    begin
        st_next     = st_reg;
        mode_next   = mode_reg;
        esc_next    = esc_reg;
        cmd_next    = cmd_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        rd_idx_next = rd_idx_reg;
        ovalid_next = ovalid_reg && !out_ch.ready;
        okind_next  = okind_reg;
        ovalue_next = ovalue_reg;
        olast_next  = olast_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        content     = 1'b0;
        emit_err    = 1'b0;
        emit_frame  = 1'b0;

        case (st_reg)
            S_IDLE:
            begin
                if (in_acc && (in_ch.action == ACT_TICK))
                begin
                    // Count idle time; drop back to idle at the timeout
                    cnt_next = cnt_inc[TICK_W-1:0];
                    if (cnt_inc >= {1'b0, timeout_reg})
                    begin
                        mode_next = MODE_IDLE;
                        cnt_next  = '0;
                    end
                end
                else if (in_acc)
                begin
                    cnt_next = '0;
                    if (!esc_reg)
                    begin
                        if (in_ch.data_byte == CH_DLE)
                            esc_next = 1'b1;
                        else
                            content = 1'b1;
                    end
                    else
                    begin
                        esc_next = 1'b0;
                        if (in_ch.data_byte == CH_DLE)
                            content = 1'b1;
                        else if (in_ch.data_byte == CH_STX)
                        begin
                            mode_next = MODE_CMD;
                            emit_err  = in_frame;
                        end
                        else if (in_ch.data_byte == CH_ETX)
                        begin
                            mode_next  = MODE_IDLE;
                            emit_frame = in_frame;
                            emit_err   = !in_frame;
                        end
                        else
                        begin
                            mode_next = MODE_IDLE;
                            emit_err  = 1'b1;
                        end
                    end

                    if (content)
                    begin
                        case (mode_reg)
                            MODE_CMD:
                            begin
                                cmd_next  = in_ch.data_byte;
                                len_next  = '0;
                                mode_next = MODE_DATA;
                            end
                            MODE_DATA:
                            begin
                                if (len_reg < LEN_W'(DATA_MAX))
                                begin
                                    mem_we   = 1'b1;
                                    len_next = len_reg + {{(LEN_W-1){1'b0}}, 1'b1};
                                end
                                else
                                begin
                                    mode_next = MODE_IDLE;
                                    emit_err  = 1'b1;
                                end
                            end
                            default:
                            begin
                                emit_err = 1'b1;
                            end
                        endcase
                    end
                end

                if (emit_err)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = KIND_ERR;
                    ovalue_next = '0;
                    olast_next  = 1'b1;
                end
                if (emit_frame)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = KIND_CMD;
                    ovalue_next = cmd_reg;
                    olast_next  = (len_reg == '0);
                    rd_idx_next = '0;
                    if (len_reg != '0)
                        st_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                mem_re  = 1'b1;
                st_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = KIND_DATA;
                    ovalue_next = mem_q;
                    olast_next  = (LEN_W'(rd_idx_reg) + {{(LEN_W-1){1'b0}}, 1'b1} == len_reg);
                    if (olast_next)
                        st_next = S_IDLE;
                    else
                    begin
                        rd_idx_next = rd_idx_reg + {{(ADDR_W-1){1'b0}}, 1'b1};
                        st_next     = S_ISSUE;
                    end
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= S_IDLE;
            mode_reg    <= MODE_IDLE;
            esc_reg     <= 1'b0;
            cmd_reg     <= '0;
            len_reg     <= '0;
            cnt_reg     <= '0;
            timeout_reg <= TIMEOUT_RESET;
            rd_idx_reg  <= '0;
            ovalid_reg  <= 1'b0;
            okind_reg   <= KIND_CMD;
            ovalue_reg  <= '0;
            olast_reg   <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            mode_reg    <= mode_next;
            esc_reg     <= esc_next;
            cmd_reg     <= cmd_next;
            len_reg     <= len_next;
            cnt_reg     <= cnt_next;
            rd_idx_reg  <= rd_idx_next;
            ovalid_reg  <= ovalid_next;
            okind_reg   <= okind_next;
            ovalue_reg  <= ovalue_next;
            olast_reg   <= olast_next;
            if (cfg_wr)
                timeout_reg <= pwdata[TICK_W-1:0];
        end
    end

    // Payload memory: write at the fill position, read during readout
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[len_reg[ADDR_W-1:0]] <= in_ch.data_byte;
        if (mem_re)
            mem_q <= mem[rd_idx_reg];
    end

    // Checks
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(DATA_MAX))
        else $error("payload length beyond capacity");

    a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != 2'd3)
        else $error("unused receive mode reached");

    a_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_ch.action == ACT_TICK)) |=> !ovalid_reg)
        else $error("tick produced a result");

    a_readout_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_IDLE) |-> !in_ch.ready)
        else $error("request taken during frame readout");

    a_etx_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_ch.action == ACT_BYTE) && esc_reg && in_frame
         && (in_ch.data_byte == CH_ETX))
        |=> (ovalid_reg && (okind_reg == KIND_CMD)))
        else $error("frame end did not start a command result");

endmodule

@@ tb/dle_stx_etx_frame_receiver_tb.sv @@
`timescale 1ns / 1ps

module dle_stx_etx_frame_receiver_tb;
    import dlefr_pkg::*;

    // One result item as it leaves out_ch
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] value;
        logic              last;
    } result_t;

    // One row of the directed table. Rows with typed set carry their expected
    // result by hand; the others are checked against the shadow deframer.
    typedef struct packed {
        logic              act;
        logic [BYTE_W-1:0] raw;
        logic              typed;
        logic              has_res;
        result_t           res;
    } dir_row_t;

    localparam result_t ERR_RES  = '{KIND_ERR, 8'h00, 1'b1};
    localparam result_t NO_RES   = '0;
    // Command byte of zero with an empty payload: what DLE STX DLE ETX
    // gives straight after reset
    localparam result_t ZERO_CMD = '{KIND_CMD, 8'h00, 1'b1};

    localparam int DIR_N = 27;
    localparam dir_row_t DIR_TAB [DIR_N] = '{
        '{ACT_TICK, 8'h00, 1'b1, 1'b0, NO_RES},   // tick at reset: nothing comes out
        '{ACT_BYTE, 8'h55, 1'b1, 1'b1, ERR_RES},  // stray byte while idle
        '{ACT_BYTE, CH_DLE, 1'b1, 1'b0, NO_RES},
        '{ACT_BYTE, CH_DLE, 1'b1, 1'b1, ERR_RES}, // doubled DLE while idle
        '{ACT_BYTE, CH_DLE, 1'b1, 1'b0, NO_RES},
        '{ACT_BYTE, CH_ETX, 1'b1, 1'b1, ERR_RES}, // ETX while idle
        '{ACT_BYTE, CH_DLE, 1'b1, 1'b0, NO_RES},
        '{ACT_BYTE, CH_STX, 1'b1, 1'b0, NO_RES},
        '{ACT_BYTE, CH_DLE, 1'b1, 1'b0, NO_RES},
        '{ACT_BYTE, CH_ETX, 1'b1, 1'b1, ZERO_CMD}, // ETX before any command byte
        '{ACT_BYTE, CH_DLE, 1'b0, 1'b0, NO_RES},
        '{ACT_BYTE, CH_STX, 1'b0, 1'b0, NO_RES},
        '{ACT_BYTE, 8'hFF, 1'b0, 1'b0, NO_RES},   // command byte at the top extreme
        '{ACT_BYTE, 8'h00, 1'b0, 1'b0, NO_RES},   // data at the bottom extreme
        '{ACT_BYTE, CH_DLE, 1'b0, 1'b0, NO_RES},
        '{ACT_BYTE, CH_DLE, 1'b0, 1'b0, NO_RES},  // stuffed DLE as data
        '{ACT_BYTE, 8'h80, 1'b0, 1'b0, NO_RES},
        '{ACT_BYTE, CH_DLE, 1'b0, 1'b0, NO_RES},
        '{ACT_BYTE, CH_ETX, 1'b0, 1'b0, NO_RES},  // frame readout, four items
        '{ACT_BYTE, CH_DLE, 1'b1, 1'b0, NO_RES},
        '{ACT_BYTE, CH_STX, 1'b1, 1'b0, NO_RES},
        '{ACT_BYTE, 8'hA5, 1'b1, 1'b0, NO_RES},
        '{ACT_BYTE, CH_DLE, 1'b1, 1'b0, NO_RES},
        '{ACT_BYTE, CH_STX, 1'b1, 1'b1, ERR_RES}, // STX inside a frame
        '{ACT_BYTE, CH_DLE, 1'b1, 1'b0, NO_RES},
        '{ACT_BYTE, 8'h7F, 1'b1, 1'b1, ERR_RES},  // unknown escape
        '{ACT_TICK, 8'hFF, 1'b1, 1'b0, NO_RES}
    };

    // Timeout settings for the random phases after the first one, which runs
    // at the reset value. Both extremes are in the list.
    localparam int N_PHASES = 4;
    localparam logic [TICK_W-1:0] PHASE_TIMEOUTS [N_PHASES] = '{
        16'd1, 16'hFFFF, 16'd2, 16'd6
    };
    localparam int PHASE_ITEMS  = 45;
    localparam int LAST_ITEMS   = 50;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 500000;

    logic clk;
    logic rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    dlefr_in_if  in_ch ();
    dlefr_out_if out_ch ();

    dle_stx_etx_frame_receiver uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the receiver state
    logic [1:0]        sh_mode;
    logic              sh_esc;
    logic [BYTE_W-1:0] sh_cmd;
    logic [BYTE_W-1:0] sh_mem [DATA_MAX];
    int                sh_len;
    int                sh_ticks;
    logic [TICK_W-1:0] sh_timeout;

    result_t step_items [$];   // results of the request just taken
    result_t deframed_q [$];   // results still owed by the block

    int fail_count  = 0;
    int sent_items  = 0;
    int cycle_count = 0;
    bit idle_on     = 1'b1;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shadow deframer
    // ------------------------------------------------------------------

    // Take one byte of frame content: command byte first, then payload.
    task automatic shadow_content(input logic [BYTE_W-1:0] d);
        if (sh_mode == MODE_CMD)
        begin
            sh_cmd  = d;
            sh_len  = 0;
            sh_mode = MODE_DATA;
        end
        else if (sh_mode == MODE_DATA)
        begin
            if (sh_len < DATA_MAX)
            begin
                sh_mem[sh_len] = d;
                sh_len++;
            end
            else
            begin
                // payload full: drop the byte and fall back to idle
                sh_mode = MODE_IDLE;
                step_items.push_back(ERR_RES);
            end
        end
        else
            step_items.push_back(ERR_RES);
    endtask

    // Queue the held frame: command byte, then each stored byte, last marked.
    task automatic shadow_frame();
        step_items.push_back('{KIND_CMD, sh_cmd, sh_len == 0});
        for (int i = 0; i < sh_len; i++)
            step_items.push_back('{KIND_DATA, sh_mem[i], i + 1 == sh_len});
    endtask

    task automatic deframe_step(input logic act, input logic [BYTE_W-1:0] raw);
        logic framed;
        step_items.delete();
        if (act == ACT_TICK)
        begin
            // ticks count idle time; the escape flag survives a timeout
            sh_ticks++;
            if (sh_ticks >= int'(sh_timeout))
            begin
                sh_mode  = MODE_IDLE;
                sh_ticks = 0;
            end
        end
        else
        begin
            sh_ticks = 0;
            framed   = (sh_mode == MODE_CMD) || (sh_mode == MODE_DATA);
            if (!sh_esc)
            begin
                if (raw == CH_DLE)
                    sh_esc = 1'b1;
                else
                    shadow_content(raw);
            end
            else
            begin
                sh_esc = 1'b0;
                if (raw == CH_DLE)
                    shadow_content(raw);
                else if (raw == CH_STX)
                begin
                    sh_mode = MODE_CMD;
                    if (framed)
                        step_items.push_back(ERR_RES);
                end
                else if (raw == CH_ETX)
                begin
                    sh_mode = MODE_IDLE;
                    if (framed)
                        shadow_frame();
                    else
                        step_items.push_back(ERR_RES);
                end
                else
                begin
                    sh_mode = MODE_IDLE;
                    step_items.push_back(ERR_RES);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Present one request at the falling edge and hold it until the rising
    // edge that takes it. Valid stays high afterwards; the next request or
    // an explicit release lowers or replaces it at the next falling edge.
    task automatic drive_request(input logic act, input logic [BYTE_W-1:0] raw);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.action    = act;
        in_ch.data_byte = raw;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sent_items++;
    endtask

    task automatic send_request(input logic act, input logic [BYTE_W-1:0] raw);
        drive_request(act, raw);
        deframe_step(act, raw);
        foreach (step_items[k])
            deframed_q.push_back(step_items[k]);
    endtask

    // Random byte, with the line control characters well represented
    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return CH_DLE;
            1:       return CH_STX;
            2:       return CH_ETX;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Send one content byte, doubling a DLE
    task automatic send_stuffed(input logic [BYTE_W-1:0] b);
        if (b == CH_DLE)
            send_request(ACT_BYTE, CH_DLE);
        send_request(ACT_BYTE, b);
    endtask

    task automatic tick_burst(input int max_n);
        repeat ($urandom_range(1, max_n))
            send_request(ACT_TICK, 8'($urandom_range(0, 255)));
    endtask

    // Well-formed frame with random content. Most lengths are short; a few
    // fill the payload exactly or overrun it by a byte or two.
    task automatic send_frame();
        int n;
        int r;
        r = $urandom_range(0, 19);
        if (r < 16)
            n = $urandom_range(0, 5);
        else if (r < 18)
            n = DATA_MAX;
        else if (r == 18)
            n = DATA_MAX + $urandom_range(1, 2);
        else
            n = $urandom_range(6, DATA_MAX - 1);
        send_request(ACT_BYTE, CH_DLE);
        send_request(ACT_BYTE, CH_STX);
        send_stuffed(pick_byte());
        for (int k = 0; k < n; k++)
        begin
            // occasionally stall the line with ticks, enough to time out under a short timeout
            if ($urandom_range(0, 29) == 0)
                tick_burst(4);
            send_stuffed(pick_byte());
        end
        send_request(ACT_BYTE, CH_DLE);
        send_request(ACT_BYTE, CH_ETX);
    endtask

    task automatic run_random(input int n);
        int stop_at;
        int r;
        logic [BYTE_W-1:0] b;
        stop_at = sent_items + n;
        while (sent_items < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                send_frame();
            else if (r < 68)
            begin
                // ETX right after STX: replays the held frame
                send_request(ACT_BYTE, CH_DLE);
                send_request(ACT_BYTE, CH_STX);
                send_request(ACT_BYTE, CH_DLE);
                send_request(ACT_BYTE, CH_ETX);
            end
            else if (r < 76)
            begin
                // open a frame and leave it; what follows breaks or restarts it
                send_request(ACT_BYTE, CH_DLE);
                send_request(ACT_BYTE, CH_STX);
                repeat ($urandom_range(1, 4))
                    send_stuffed(pick_byte());
            end
            else if (r < 84)
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_DLE || b == CH_STX || b == CH_ETX);
                send_request(ACT_BYTE, CH_DLE);
                send_request(ACT_BYTE, b);
            end
            else if (r < 93)
            begin
                repeat ($urandom_range(1, 3))
                    send_request(ACT_BYTE, pick_byte());
            end
            else
                tick_burst(8);
        end
    endtask

    // Drop valid, wait for every owed result, then let the block go quiet
    task automatic settle();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (deframed_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------

    task automatic write_timeout(input logic [TICK_W-1:0] v);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {REG_TIMEOUT, 2'b00};
        pwdata  = {{(PDATA_W - TICK_W){1'b0}}, v};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sh_timeout = v;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_timeout(input logic [TICK_W-1:0] v);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {REG_TIMEOUT, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {{(PDATA_W - TICK_W){1'b0}}, v})
        begin
            $error("timeout_ticks: expected %0d, got %0d", v, prdata);
            fail_count++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Stall the result channel in short random bursts while idling is on
    initial
    begin
        out_ch.ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                out_ch.ready = 1'b1;
            end
        end
    end

    // Compare each taken result with the oldest owed one
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (deframed_q.size() == 0)
            begin
                $error("unexpected result: kind %0d value 0x%02h last %0d",
                       out_ch.kind, out_ch.value, out_ch.last);
                fail_count++;
            end
            else
            begin
                want = deframed_q.pop_front();
                if (out_ch.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
                    fail_count++;
                end
                if (out_ch.value !== want.value)
                begin
                    $error("value: expected 0x%02h, got 0x%02h", want.value, out_ch.value);
                    fail_count++;
                end
                if (out_ch.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, out_ch.last);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.action    = ACT_BYTE;
        in_ch.data_byte = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;

        // shadow state after reset; the payload store stays unread until written
        sh_mode    = MODE_IDLE;
        sh_esc     = 1'b0;
        sh_cmd     = '0;
        sh_len     = 0;
        sh_ticks   = 0;
        sh_timeout = TIMEOUT_RESET;
        foreach (sh_mem[i])
            sh_mem[i] = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        check_timeout(TIMEOUT_RESET);

        // Walk the directed table; the shadow tracks state on every row
        for (int i = 0; i < DIR_N; i++)
        begin
            drive_request(DIR_TAB[i].act, DIR_TAB[i].raw);
            deframe_step(DIR_TAB[i].act, DIR_TAB[i].raw);
            if (DIR_TAB[i].typed)
            begin
                if (DIR_TAB[i].has_res)
                    deframed_q.push_back(DIR_TAB[i].res);
            end
            else
                foreach (step_items[k])
                    deframed_q.push_back(step_items[k]);
        end

        // First random phase at the reset timeout
        run_random(PHASE_ITEMS);

        // Retune the timeout only once the block has gone quiet
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            settle();
            write_timeout(PHASE_TIMEOUTS[ph]);
            check_timeout(PHASE_TIMEOUTS[ph]);
            if (ph == N_PHASES - 1)
            begin
                // run the tail at full rate on both sides
                idle_on = 1'b0;
                run_random(LAST_ITEMS);
            end
            else
                run_random(PHASE_ITEMS);
        end

        settle();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
src/dlefr_pkg.sv
src/dlefr_if.sv
src/dle_stx_etx_frame_receiver.sv
tb/dle_stx_etx_frame_receiver_tb.sv
